// ===== rtl/snis_pkg.sv =====
// Shared types, field widths and command/status codes for the sorted node id set.
// No dependencies; every other file of the block imports this package.
package snis_pkg;

    localparam int ID_W           = 11;
    localparam int CMD_W          = 2;
    localparam int STATUS_W       = 2;
    localparam int POS_W          = 6;
    localparam int COUNT_W        = 7;
    localparam int LIST_DEPTH_DEF = 64;

    typedef logic [ID_W-1:0]     id_t;
    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [POS_W-1:0]    pos_t;
    typedef logic [COUNT_W-1:0]  count_t;

    // Command codes; the unused code behaves as a lookup.
    localparam cmd_t CMD_LOOKUP = 2'd0;
    localparam cmd_t CMD_ADD    = 2'd1;
    localparam cmd_t CMD_REMOVE = 2'd2;

    // Result status codes.
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_FULL      = 2'd1;
    localparam status_t ST_NOT_FOUND = 2'd2;
    localparam status_t ST_INVALID   = 2'd3;

    localparam id_t ID_INVALID = 11'd0;

endpackage

// ===== rtl/snis_if.sv =====
// Valid/ready channel interfaces for command and response transactions.
// Depends on snis_pkg for the payload types.
interface snis_cmd_if;
    import snis_pkg::*;

    logic valid;
    logic ready;
    cmd_t cmd;
    id_t  node_id;

    modport source (output valid, output cmd, output node_id, input ready);
    modport sink   (input valid, input cmd, input node_id, output ready);
endinterface

interface snis_rsp_if;
    import snis_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;
    logic    found;
    pos_t    position;
    count_t  entry_count;

    modport source (output valid, output status, output found, output position,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input found, input position,
                    input entry_count, output ready);
endinterface

// ===== rtl/snis_cell.sv =====
// One storage cell of the identifier ring: holds one entry and loads its neighbor's.
// Depends on snis_pkg.
module snis_cell
(
    input  logic          clk,
    input  logic          shift_en,
    input  snis_pkg::id_t data_in,
    output snis_pkg::id_t data_out
);
    import snis_pkg::*;

    id_t data_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            data_reg <= data_in;
        end
    end

    assign data_out = data_reg;

endmodule

// ===== rtl/snis_chain.sv =====
// Row of snis_cell instances forming a shift line; the tail is fed by the controller.
// Depends on snis_pkg and snis_cell.
module snis_chain
#(
    parameter int LIST_DEPTH = snis_pkg::LIST_DEPTH_DEF
)
(
    input  logic          clk,
    input  logic          shift_en,
    input  snis_pkg::id_t tail_data,
    output snis_pkg::id_t head_data,
    output snis_pkg::id_t head_next_data
);
    import snis_pkg::*;

    id_t cell_out [LIST_DEPTH];
    id_t cell_in  [LIST_DEPTH];

    genvar i;
    generate
        for (i = 0; i < LIST_DEPTH; i++)
        begin : g_cell
            if (i == LIST_DEPTH - 1)
            begin : g_tail
                assign cell_in[i] = tail_data;
            end
            else
            begin : g_body
                assign cell_in[i] = cell_out[i+1];
            end

            snis_cell u_cell
            (
                .clk      (clk),
                .shift_en (shift_en),
                .data_in  (cell_in[i]),
                .data_out (cell_out[i])
            );
        end

        if (LIST_DEPTH > 1)
        begin : g_next
            assign head_next_data = cell_out[1];
        end
        else
        begin : g_no_next
            assign head_next_data = cell_out[0];
        end
    endgenerate

    assign head_data = cell_out[0];

endmodule

// ===== rtl/sorted_node_id_set_unit.sv =====
// Sorted node id set: keeps an ascending, duplicate-free list of up to LIST_DEPTH
// non-zero 11-bit node identifiers and runs lookup, add and remove commands on it.
// Depends on snis_pkg, snis_if, snis_chain and snis_cell.
//
// The list lives in a ring of LIST_DEPTH cells that all shift toward the head in
// every cycle of the run state. The controller looks at the head cell (and its
// neighbor) and decides what value re-enters the ring at the tail, so one full
// rotation both searches the list and, for add or remove, rewrites it with the new
// identifier slotted in or the removed one squeezed out.
// A command with identifier 0 skips the rotation. While the previous response has
// not been taken, the finished command waits in the finish state. One command is
// worked on at a time, but a new command transaction is accepted while the previous
// response still waits in the output register. Each command yields exactly one
// response transaction. Identifier 0 is rejected with the invalid status and leaves
// the list unchanged; command code 3 behaves as a lookup. Cell contents need no
// reset, since only entries below the stored count are ever compared.
module sorted_node_id_set_unit
#(
    parameter int LIST_DEPTH = snis_pkg::LIST_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    snis_cmd_if.sink   req,
    snis_rsp_if.source rsp
);
    import snis_pkg::*;

    // Step counter indexes the ring; the count needs one more value (a full list).
    localparam int SW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FINISH
    } state_t;

    state_t          state_reg,    state_next;
    logic [SW-1:0]   step_reg,     step_next;
    logic [CW-1:0]   count_reg,    count_next;
    cmd_t            cmd_reg,      cmd_next;
    id_t             id_reg,       id_next;
    logic            invalid_reg,  invalid_next;
    logic            hit_reg,      hit_next;
    logic [SW-1:0]   pos_reg,      pos_next;
    logic            inserted_reg, inserted_next;
    logic            removing_reg, removing_next;
    id_t             hold_reg,     hold_next;

    logic            out_valid_reg,  out_valid_next;
    status_t         out_status_reg, out_status_next;
    logic            out_found_reg,  out_found_next;
    pos_t            out_pos_reg,    out_pos_next;
    count_t          out_count_reg,  out_count_next;

    logic            shift_en;
    id_t             tail_data;
    id_t             head_data;
    id_t             head_next_data;

    logic            is_add;
    logic            is_remove;
    logic            live;
    logic            can_add;
    logic            cmp_ok;
    logic            match;
    logic            slot_here;
    logic            out_free;
    logic [CW-1:0]   step_ext;
    logic [CW-1:0]   final_count;
    status_t         final_status;
    logic [SW+POS_W-1:0]   pos_wide;
    logic [CW+COUNT_W-1:0] count_wide;

    snis_chain #(.LIST_DEPTH(LIST_DEPTH)) u_chain
    (
        .clk            (clk),
        .shift_en       (shift_en),
        .tail_data      (tail_data),
        .head_data      (head_data),
        .head_next_data (head_next_data)
    );

    assign shift_en = (state_reg == S_RUN);
    assign req.ready = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || rsp.ready;

    assign is_add    = (cmd_reg == CMD_ADD);
    assign is_remove = (cmd_reg == CMD_REMOVE);
    assign step_ext  = CW'(step_reg);
    assign live      = (step_ext < count_reg);
    assign can_add   = (count_reg < CW'(LIST_DEPTH));
    // Compare entries until the identifier is found or has been placed.
    assign cmp_ok    = live && !hit_reg && !inserted_reg;
    assign match     = cmp_ok && (head_data == id_reg);
    // Sorted place of a new identifier: first larger entry, or the end of the list.
    assign slot_here = !hit_reg && !inserted_reg &&
                       ((cmp_ok && (head_data > id_reg)) || (step_ext == count_reg));

    // Value re-entering the ring; written at step s it settles in cell s.
    always_comb
    begin
        tail_data     = head_data;
        hit_next      = hit_reg;
        pos_next      = pos_reg;
        inserted_next = inserted_reg;
        removing_next = removing_reg;
        hold_next     = hold_reg;

        if (removing_reg)
        begin
            tail_data = head_next_data;
        end
        else if (inserted_reg)
        begin
            // Entries after the new one move up by one place.
            tail_data = hold_reg;
            hold_next = head_data;
        end

        if (match)
        begin
            hit_next = 1'b1;
            pos_next = step_reg;
            if (is_remove)
            begin
                tail_data     = head_next_data;
                removing_next = 1'b1;
            end
        end
        else if (is_add && can_add && slot_here)
        begin
            tail_data     = id_reg;
            hold_next     = head_data;
            inserted_next = 1'b1;
        end
    end

    // Result of the finished command.
    always_comb
    begin
        final_count = count_reg;
        if (inserted_reg)
        begin
            final_count = count_reg + CW'(1);
        end
        else if (is_remove && hit_reg)
        begin
            final_count = count_reg - CW'(1);
        end

        if (invalid_reg)
        begin
            final_status = ST_INVALID;
        end
        else if (hit_reg || inserted_reg)
        begin
            final_status = ST_OK;
        end
        else if (is_add)
        begin
            final_status = ST_FULL;
        end
        else
        begin
            final_status = ST_NOT_FOUND;
        end
    end

    assign pos_wide   = (SW + POS_W)'(pos_reg);
    assign count_wide = (CW + COUNT_W)'(final_count);

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        count_next      = count_reg;
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        invalid_next    = invalid_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_pos_next    = out_pos_reg;
        out_count_next  = out_count_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next     = req.cmd;
                    id_next      = req.node_id;
                    invalid_next = (req.node_id == ID_INVALID);
                    step_next    = '0;
                    state_next   = (req.node_id == ID_INVALID) ? S_FINISH : S_RUN;
                end
            end
            S_RUN:
            begin
                if (step_reg == SW'(LIST_DEPTH - 1))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    step_next = step_reg + SW'(1);
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = final_status;
                    out_found_next  = hit_reg;
                    out_pos_next    = hit_reg ? pos_wide[POS_W-1:0] : '0;
                    out_count_next  = count_wide[COUNT_W-1:0];
                    count_next      = final_count;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= '0;
            count_reg      <= '0;
            cmd_reg        <= CMD_LOOKUP;
            id_reg         <= ID_INVALID;
            invalid_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            pos_reg        <= '0;
            inserted_reg   <= 1'b0;
            removing_reg   <= 1'b0;
            hold_reg       <= ID_INVALID;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            out_found_reg  <= 1'b0;
            out_pos_reg    <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            count_reg      <= count_next;
            cmd_reg        <= cmd_next;
            id_reg         <= id_next;
            invalid_reg    <= invalid_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_found_reg  <= out_found_next;
            out_pos_reg    <= out_pos_next;
            out_count_reg  <= out_count_next;
            if (state_reg == S_IDLE)
            begin
                // Search flags start clear for every new command.
                hit_reg      <= 1'b0;
                pos_reg      <= '0;
                inserted_reg <= 1'b0;
                removing_reg <= 1'b0;
            end
            else if (state_reg == S_RUN)
            begin
                hit_reg      <= hit_next;
                pos_reg      <= pos_next;
                inserted_reg <= inserted_next;
                removing_reg <= removing_next;
                hold_reg     <= hold_next;
            end
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.found       = out_found_reg;
    assign rsp.position    = out_pos_reg;
    assign rsp.entry_count = out_count_reg;

endmodule
